// File: design/page_replacement_fifo_lru_macros.svh
// Assertion macros used by the checker file of the page replacement unit.
`ifndef PAGE_REPLACEMENT_FIFO_LRU_MACROS_SVH
`define PAGE_REPLACEMENT_FIFO_LRU_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PRF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page replacement check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page replacement check failed");

`endif

// File: design/prf_pkg.sv
// Shared constants, codes and control types of the page replacement unit.
package prf_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);

    localparam int ADDR_W     = 16;
    localparam int PAGE_W     = 8;
    localparam int SLOT_W     = 4;
    localparam int TOTAL_W    = 16;
    localparam int STAMP_W    = 32;
    localparam int FC_W       = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [FC_W-1:0] FRAME_COUNT_RESET = 5'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE        = 1'b0,
        REG_FRAME_COUNT = 1'b1
    } reg_index_t;

    typedef enum logic {
        MODE_FIFO = 1'b0,
        MODE_LRU  = 1'b1
    } policy_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic update;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic match;
        logic last;
    } status_t;

endpackage

// File: design/prf_ctrl.sv
// Sequencer of the page replacement unit: accept, scan, update, emit.
module prf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  prf_pkg::status_t status,
    output prf_pkg::cmd_t    cmd
);
    import prf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.match || status.last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold until the output register is free or being drained
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: design/prf_dpath.sv
// Frame table, stamps, counters, config registers and result register.
module prf_dpath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [prf_pkg::ADDR_W-1:0]        address,
    input  logic                              cfg_write,
    input  logic [prf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [prf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  prf_pkg::cmd_t                     cmd,
    output prf_pkg::status_t                  status,
    output logic [prf_pkg::PAGE_W-1:0]        page,
    output logic                              fault,
    output logic [prf_pkg::SLOT_W-1:0]        slot,
    output logic [prf_pkg::TOTAL_W-1:0]       fault_total
);
    import prf_pkg::*;

    policy_t            mode_reg;
    logic [FC_W-1:0]    frame_count_reg;

    logic [PAGE_W-1:0]  pages_reg  [MAX_FRAMES];
    logic [STAMP_W-1:0] stamps_reg [MAX_FRAMES];
    logic [CNT_W-1:0]   filled_reg;
    logic [IDX_W-1:0]   fill_ptr_reg;
    logic [STAMP_W-1:0] stamp_cnt_reg;
    logic [TOTAL_W-1:0] faults_reg;

    logic [PAGE_W-1:0]  page_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic [STAMP_W-1:0] least_reg;
    logic [IDX_W-1:0]   victim_reg;

    logic [PAGE_W-1:0]  page_out_reg;
    logic               fault_out_reg;
    logic [SLOT_W-1:0]  slot_out_reg;
    logic [TOTAL_W-1:0] total_out_reg;

    logic [CNT_W-1:0]   n_eff;
    logic [CNT_W-1:0]   occ;
    logic [CNT_W-1:0]   idx_ext;
    logic [IDX_W-1:0]   fifo_slot;
    logic [CNT_W-1:0]   fifo_inc;
    logic [IDX_W-1:0]   fifo_ptr_next;
    logic [IDX_W-1:0]   lru_slot;
    logic [STAMP_W-1:0] stamp_inc;
    logic               room;

    // effective frame count: zero acts as one, clamp to the table size
    always_comb
    begin
        priority if (frame_count_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (int'(frame_count_reg) > MAX_FRAMES)
        begin
            n_eff = CNT_W'(MAX_FRAMES);
        end
        else
        begin
            n_eff = CNT_W'(frame_count_reg);
        end
    end

    assign room      = (filled_reg < n_eff);
    assign occ       = room ? filled_reg : n_eff;
    assign idx_ext   = CNT_W'(idx_reg);
    assign stamp_inc = stamp_cnt_reg + STAMP_W'(1);

    assign status.match = (pages_reg[idx_reg] == page_reg) && (idx_ext < occ);
    assign status.last  = (idx_ext == (n_eff - CNT_W'(1)));

    assign fifo_slot     = (CNT_W'(fill_ptr_reg) < n_eff) ? fill_ptr_reg : '0;
    assign fifo_inc      = CNT_W'(fifo_slot) + CNT_W'(1);
    assign fifo_ptr_next = (fifo_inc >= n_eff) ? '0 : IDX_W'(fifo_inc);
    assign lru_slot      = room ? IDX_W'(filled_reg) : victim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_FIFO;
            frame_count_reg <= FRAME_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_MODE:        mode_reg        <= policy_t'(cfg_data[0]);
                REG_FRAME_COUNT: frame_count_reg <= FC_W'(cfg_data);
                default:         mode_reg        <= mode_reg;
            endcase
        end
    end

    // table state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                pages_reg[i]  <= '0;
                stamps_reg[i] <= '0;
            end
            filled_reg    <= '0;
            fill_ptr_reg  <= '0;
            stamp_cnt_reg <= '0;
            faults_reg    <= '0;
        end
        else if (cmd.update)
        begin
            if (hit_reg)
            begin
                if (mode_reg == MODE_LRU)
                begin
                    stamp_cnt_reg        <= stamp_inc;
                    stamps_reg[slot_reg] <= stamp_inc;
                end
            end
            else
            begin
                if (faults_reg != '1)
                begin
                    faults_reg <= faults_reg + TOTAL_W'(1);
                end
                if (room)
                begin
                    filled_reg <= filled_reg + CNT_W'(1);
                end
                if (mode_reg == MODE_FIFO)
                begin
                    pages_reg[fifo_slot] <= page_reg;
                    fill_ptr_reg         <= fifo_ptr_next;
                end
                else
                begin
                    pages_reg[lru_slot]  <= page_reg;
                    stamps_reg[lru_slot] <= stamp_inc;
                    stamp_cnt_reg        <= stamp_inc;
                end
            end
        end
    end

    // per-request working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg <= address[ADDR_W-1 -: PAGE_W];
            idx_reg  <= '0;
            hit_reg  <= 1'b0;
        end
        if (cmd.scan)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
            if (status.match)
            begin
                hit_reg  <= 1'b1;
                slot_reg <= idx_reg;
            end
            if ((idx_reg == '0) || (stamps_reg[idx_reg] < least_reg))
            begin
                least_reg  <= stamps_reg[idx_reg];
                victim_reg <= idx_reg;
            end
        end
        if (cmd.update && !hit_reg)
        begin
            slot_reg <= (mode_reg == MODE_FIFO) ? fifo_slot : lru_slot;
        end
        if (cmd.emit)
        begin
            page_out_reg  <= page_reg;
            fault_out_reg <= !hit_reg;
            slot_out_reg  <= SLOT_W'(slot_reg);
            total_out_reg <= faults_reg;
        end
    end

    assign page        = page_out_reg;
    assign fault       = fault_out_reg;
    assign slot        = slot_out_reg;
    assign fault_total = total_out_reg;

endmodule

// File: design/page_replacement_fifo_lru.sv
// Top level of the FIFO / LRU page replacement unit.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------
//   in      | to block  | in_valid / in_stall  | address
//   out     | from block| out_valid / out_stall| page, fault, slot, fault_total
//   cfg     | to block  | cfg_write            | cfg_index, cfg_data
//
// One request at a time. After acceptance the frame table is scanned one
// frame per cycle by a single page compare and stamp compare; the scan stops
// at the first hit or at the last active frame. Then an update step, a step
// to load the result register, and a return to the idle state to take the
// next request.
// Reset clears the frame table, the stamps and all counters at once; no sweep.
// A waiting result does not block the next request; the block only holds in
// the emit step while the previous result is still stalled.
module page_replacement_fifo_lru (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [prf_pkg::ADDR_W-1:0]        address,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [prf_pkg::PAGE_W-1:0]        page,
    output logic                              fault,
    output logic [prf_pkg::SLOT_W-1:0]        slot,
    output logic [prf_pkg::TOTAL_W-1:0]       fault_total,
    input  logic                              cfg_write,
    input  logic [prf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [prf_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import prf_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer: request handshake, scan length, result handoff
    prf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: frame table, policy state, config and result register
    prf_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .address     (address),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status),
        .page        (page),
        .fault       (fault),
        .slot        (slot),
        .fault_total (fault_total)
    );

endmodule

// File: design/prf_checker.sv
// Port-level checks of the page replacement unit, bound to the top level.
`include "page_replacement_fifo_lru_macros.svh"

module prf_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [prf_pkg::PAGE_W-1:0]        page,
    input logic                              fault,
    input logic [prf_pkg::SLOT_W-1:0]        slot,
    input logic [prf_pkg::TOTAL_W-1:0]       fault_total
);
    import prf_pkg::*;

    logic [PAGE_W+SLOT_W+TOTAL_W:0] result_bits;

    assign result_bits = {page, fault, slot, fault_total};

    // a taken request always starts a scan, so intake closes next cycle
    `PRF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // a stalled result holds
    `PRF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result_bits))

    // a fault is counted before it is reported, and the count saturates
    `PRF_ASSERT_NOW(a_fault_counted, out_valid && fault, fault_total != '0)

endmodule

bind page_replacement_fifo_lru prf_checker u_prf_checker (.*);
